FILE: rtl/core/zupt_axis_dead_reckoning_core_defines.svh
// Assertion macros shared by the dead-reckoning core modules.
`ifndef ZUPT_AXIS_DEAD_RECKONING_CORE_DEFINES_SVH
`define ZUPT_AXIS_DEAD_RECKONING_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define ZUPT_ASSERT_IMP(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ZUPT_ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/core/zupt_pkg.sv
// Types, constants and codes shared by the dead-reckoning core.
package zupt_pkg;

    localparam int ACC_W      = 24;
    localparam int DIFF_W     = ACC_W + 1;
    localparam int VAL_W      = 32;
    localparam int SUM_W      = VAL_W + 2;
    localparam int DT_W       = 20;
    localparam int RUN_W      = 16;
    localparam int FACT_W     = 16;
    localparam int BAND_W     = 23;
    localparam int SNAP_W     = 31;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int MAG_W      = 32;
    localparam int K_W        = 20;
    localparam int PROD_W     = MAG_W + K_W;
    localparam int TIME_SHIFT = 20;
    localparam int FACT_SHIFT = 16;

    localparam logic [PROD_W-1:0] HALF_TIME = PROD_W'(1) << (TIME_SHIFT - 1);
    localparam logic [PROD_W-1:0] HALF_FACT = PROD_W'(1) << (FACT_SHIFT - 1);

    localparam logic [RUN_W-1:0]        RUN_MAX = '1;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    localparam logic [BAND_W-1:0] RST_ACCEL_DEADBAND   = 23'd1966;
    localparam logic [BAND_W-1:0] RST_BIAS_TRACK_LIMIT = 23'd22938;
    localparam logic [SNAP_W-1:0] RST_VELOCITY_SNAP    = 31'd131;
    localparam logic [FACT_W-1:0] RST_BIAS_WEIGHT      = 16'd655;
    localparam logic [FACT_W-1:0] RST_VELOCITY_DECAY   = 16'd65470;
    localparam logic [RUN_W-1:0]  RST_HOLD_COUNT       = 16'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL_DEADBAND   = 3'd0,
        CFG_BIAS_TRACK_LIMIT = 3'd1,
        CFG_VELOCITY_SNAP    = 3'd2,
        CFG_BIAS_WEIGHT      = 3'd3,
        CFG_VELOCITY_DECAY   = 3'd4,
        CFG_HOLD_COUNT       = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [BAND_W-1:0] accel_deadband;
        logic [BAND_W-1:0] bias_track_limit;
        logic [SNAP_W-1:0] velocity_snap;
        logic [FACT_W-1:0] bias_weight;
        logic [FACT_W-1:0] velocity_decay;
        logic [RUN_W-1:0]  hold_count;
    } cfg_t;

    typedef struct packed {
        logic                    func;
        logic signed [ACC_W-1:0] accel_sample;
        logic [DT_W-1:0]         time_step;
        logic                    still;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] position;
        logic signed [VAL_W-1:0] velocity;
        logic signed [ACC_W-1:0] accel_used;
        logic signed [ACC_W-1:0] bias_now;
        logic                    held;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP,
        ST_DECIDE,
        ST_BIAS_MUL,
        ST_BIAS_ADD,
        ST_VEL_MUL,
        ST_VEL_ADD,
        ST_DECAY_MUL,
        ST_DECAY_SET,
        ST_POS_MUL,
        ST_POS_ADD,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_STEP,
        OP_DECIDE,
        OP_MUL_BIAS,
        OP_ADD_BIAS,
        OP_MUL_ACC,
        OP_ADD_VEL,
        OP_MUL_DECAY,
        OP_SET_VEL,
        OP_MUL_POS,
        OP_ADD_POS,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   mul_start;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_item;
        logic hold;
        logic track;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/core/zupt_mul.sv
// Shared magnitude multiplier with round-to-nearest and a right shift of 20 or 16 bits, chosen by shift_time.
module zupt_mul (
    input  logic                        aclk,
    input  logic                        start,
    input  logic [zupt_pkg::MAG_W-1:0]  mag,
    input  logic [zupt_pkg::K_W-1:0]    k,
    input  logic                        shift_time,
    input  logic                        neg,
    output logic [zupt_pkg::MAG_W-1:0]  rmag,
    output logic                        rneg
);

    logic [zupt_pkg::PROD_W-1:0] prod;
    logic [zupt_pkg::PROD_W-1:0] sum;
    logic [zupt_pkg::MAG_W-1:0]  rnd;
    logic [zupt_pkg::MAG_W-1:0]  rmag_reg;
    logic                        rneg_reg;

    assign prod = {{zupt_pkg::K_W{1'b0}}, mag} * {{zupt_pkg::MAG_W{1'b0}}, k};
    assign sum  = prod + (shift_time ? zupt_pkg::HALF_TIME : zupt_pkg::HALF_FACT);

    // Rounded magnitude stays below 2^31 for every operand pair used here.
    assign rnd = shift_time
        ? sum[zupt_pkg::TIME_SHIFT +: zupt_pkg::MAG_W]
        : sum[zupt_pkg::FACT_SHIFT +: zupt_pkg::MAG_W];

    always_ff @(posedge aclk) begin
        if (start) begin
            rmag_reg <= rnd;
            rneg_reg <= neg;
        end
    end

    assign rmag = rmag_reg;
    assign rneg = rneg_reg;

endmodule

FILE: rtl/core/zupt_cfg.sv
// Configuration register file of the dead-reckoning core.
module zupt_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [zupt_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [zupt_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output zupt_pkg::cfg_t                    cfg
);

    zupt_pkg::cfg_t cfg_reg;
    zupt_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (zupt_pkg::cfg_index_t'(cfg_wr_index))
                zupt_pkg::CFG_ACCEL_DEADBAND: begin
                    cfg_next.accel_deadband = cfg_wr_data[zupt_pkg::BAND_W-1:0];
                end
                zupt_pkg::CFG_BIAS_TRACK_LIMIT: begin
                    cfg_next.bias_track_limit = cfg_wr_data[zupt_pkg::BAND_W-1:0];
                end
                zupt_pkg::CFG_VELOCITY_SNAP: begin
                    cfg_next.velocity_snap = cfg_wr_data[zupt_pkg::SNAP_W-1:0];
                end
                zupt_pkg::CFG_BIAS_WEIGHT: begin
                    cfg_next.bias_weight = cfg_wr_data[zupt_pkg::FACT_W-1:0];
                end
                zupt_pkg::CFG_VELOCITY_DECAY: begin
                    cfg_next.velocity_decay = cfg_wr_data[zupt_pkg::FACT_W-1:0];
                end
                zupt_pkg::CFG_HOLD_COUNT: begin
                    cfg_next.hold_count = cfg_wr_data[zupt_pkg::RUN_W-1:0];
                end
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.accel_deadband   <= zupt_pkg::RST_ACCEL_DEADBAND;
            cfg_reg.bias_track_limit <= zupt_pkg::RST_BIAS_TRACK_LIMIT;
            cfg_reg.velocity_snap    <= zupt_pkg::RST_VELOCITY_SNAP;
            cfg_reg.bias_weight      <= zupt_pkg::RST_BIAS_WEIGHT;
            cfg_reg.velocity_decay   <= zupt_pkg::RST_VELOCITY_DECAY;
            cfg_reg.hold_count       <= zupt_pkg::RST_HOLD_COUNT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/zupt_ctrl.sv
// Sequencing state machine of the dead-reckoning core.
`include "zupt_axis_dead_reckoning_core_defines.svh"

module zupt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  zupt_pkg::dp_status_t status,
    output zupt_pkg::dp_cmd_t    cmd
);

    zupt_pkg::state_t state_reg;
    zupt_pkg::state_t state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            zupt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = zupt_pkg::ST_STEP;
                end
            end
            zupt_pkg::ST_STEP: begin
                state_next = status.clear_item ? zupt_pkg::ST_OUT : zupt_pkg::ST_DECIDE;
            end
            zupt_pkg::ST_DECIDE: begin
                if (!status.hold) begin
                    state_next = zupt_pkg::ST_VEL_MUL;
                end else if (status.track) begin
                    state_next = zupt_pkg::ST_BIAS_MUL;
                end else begin
                    state_next = zupt_pkg::ST_OUT;
                end
            end
            zupt_pkg::ST_BIAS_MUL:  state_next = zupt_pkg::ST_BIAS_ADD;
            zupt_pkg::ST_BIAS_ADD:  state_next = zupt_pkg::ST_OUT;
            zupt_pkg::ST_VEL_MUL:   state_next = zupt_pkg::ST_VEL_ADD;
            zupt_pkg::ST_VEL_ADD:   state_next = zupt_pkg::ST_DECAY_MUL;
            zupt_pkg::ST_DECAY_MUL: state_next = zupt_pkg::ST_DECAY_SET;
            zupt_pkg::ST_DECAY_SET: state_next = zupt_pkg::ST_POS_MUL;
            zupt_pkg::ST_POS_MUL:   state_next = zupt_pkg::ST_POS_ADD;
            zupt_pkg::ST_POS_ADD:   state_next = zupt_pkg::ST_OUT;
            zupt_pkg::ST_OUT: begin
                if (status.out_free) begin
                    state_next = zupt_pkg::ST_IDLE;
                end
            end
            default: state_next = zupt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd.op        = zupt_pkg::OP_NONE;
        cmd.mul_start = 1'b0;
        unique case (state_reg)
            zupt_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = zupt_pkg::OP_LOAD;
                end
            end
            zupt_pkg::ST_STEP:      cmd.op = zupt_pkg::OP_STEP;
            zupt_pkg::ST_DECIDE:    cmd.op = zupt_pkg::OP_DECIDE;
            zupt_pkg::ST_BIAS_MUL: begin
                cmd.op        = zupt_pkg::OP_MUL_BIAS;
                cmd.mul_start = 1'b1;
            end
            zupt_pkg::ST_BIAS_ADD:  cmd.op = zupt_pkg::OP_ADD_BIAS;
            zupt_pkg::ST_VEL_MUL: begin
                cmd.op        = zupt_pkg::OP_MUL_ACC;
                cmd.mul_start = 1'b1;
            end
            zupt_pkg::ST_VEL_ADD:   cmd.op = zupt_pkg::OP_ADD_VEL;
            zupt_pkg::ST_DECAY_MUL: begin
                cmd.op        = zupt_pkg::OP_MUL_DECAY;
                cmd.mul_start = 1'b1;
            end
            zupt_pkg::ST_DECAY_SET: cmd.op = zupt_pkg::OP_SET_VEL;
            zupt_pkg::ST_POS_MUL: begin
                cmd.op        = zupt_pkg::OP_MUL_POS;
                cmd.mul_start = 1'b1;
            end
            zupt_pkg::ST_POS_ADD:   cmd.op = zupt_pkg::OP_ADD_POS;
            zupt_pkg::ST_OUT: begin
                // hold the result until the output register frees up
                if (status.out_free) begin
                    cmd.op = zupt_pkg::OP_EMIT;
                end
            end
            default: cmd.op = zupt_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= zupt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `ZUPT_ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_valid && s_ready, state_reg == zupt_pkg::ST_STEP, "accepted request did not start a step")
    `ZUPT_ASSERT_NEXT(a_emit_returns, aclk, aresetn, cmd.op == zupt_pkg::OP_EMIT, state_reg == zupt_pkg::ST_IDLE, "emit did not return to idle")

endmodule

FILE: rtl/core/zupt_dp.sv
// Datapath of the dead-reckoning core: state, multiplier, adders, output register.
`include "zupt_axis_dead_reckoning_core_defines.svh"

module zupt_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  zupt_pkg::cfg_t        cfg,
    input  zupt_pkg::dp_cmd_t     cmd,
    output zupt_pkg::dp_status_t  status,
    input  zupt_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output zupt_pkg::out_item_t   m_data
);

    logic                                 func_reg;
    logic signed [zupt_pkg::ACC_W-1:0]    sample_reg;
    logic [zupt_pkg::DT_W-1:0]            dt_reg;
    logic                                 still_reg;
    logic signed [zupt_pkg::DIFF_W-1:0]   diff_reg;
    logic signed [zupt_pkg::DIFF_W-1:0]   diff_next;

    logic [zupt_pkg::RUN_W-1:0]           run_reg;
    logic [zupt_pkg::RUN_W-1:0]           run_next;
    logic signed [zupt_pkg::VAL_W-1:0]    pos_reg;
    logic signed [zupt_pkg::VAL_W-1:0]    pos_next;
    logic signed [zupt_pkg::VAL_W-1:0]    vel_reg;
    logic signed [zupt_pkg::VAL_W-1:0]    vel_next;
    logic signed [zupt_pkg::ACC_W-1:0]    bias_reg;
    logic signed [zupt_pkg::ACC_W-1:0]    bias_next;
    logic signed [zupt_pkg::ACC_W-1:0]    accel_reg;
    logic signed [zupt_pkg::ACC_W-1:0]    accel_next;
    logic                                 held_reg;
    logic                                 held_next;
    logic                                 m_valid_reg;
    logic                                 m_valid_next;
    zupt_pkg::out_item_t                  m_data_reg;

    logic [zupt_pkg::DIFF_W-1:0]          diff_mag;
    logic signed [zupt_pkg::ACC_W-1:0]    acc_sat;
    logic [zupt_pkg::ACC_W-1:0]           acc_sat_mag;
    logic signed [zupt_pkg::ACC_W-1:0]    acc_db;
    logic [zupt_pkg::ACC_W-1:0]           accel_mag;
    logic [zupt_pkg::VAL_W-1:0]           vel_mag;
    logic                                 snap;

    logic [zupt_pkg::MAG_W-1:0]           mul_mag;
    logic [zupt_pkg::K_W-1:0]             mul_k;
    logic                                 mul_shift_time;
    logic                                 mul_neg;
    logic [zupt_pkg::MAG_W-1:0]           mul_rmag;
    logic                                 mul_rneg;

    function automatic logic signed [zupt_pkg::VAL_W-1:0] sat_addsub(
        input logic signed [zupt_pkg::VAL_W-1:0] a,
        input logic [zupt_pkg::MAG_W-1:0]        m,
        input logic                              sub
    );
        logic signed [zupt_pkg::SUM_W-1:0] s;
        logic signed [zupt_pkg::SUM_W-1:0] a_ext;
        logic signed [zupt_pkg::SUM_W-1:0] m_ext;
        a_ext = {{(zupt_pkg::SUM_W-zupt_pkg::VAL_W){a[zupt_pkg::VAL_W-1]}}, a};
        m_ext = {{(zupt_pkg::SUM_W-zupt_pkg::MAG_W){1'b0}}, m};
        s     = sub ? (a_ext - m_ext) : (a_ext + m_ext);
        if (s > zupt_pkg::SUM_W'(zupt_pkg::VAL_MAX)) begin
            return zupt_pkg::VAL_MAX;
        end else if (s < zupt_pkg::SUM_W'(zupt_pkg::VAL_MIN)) begin
            return zupt_pkg::VAL_MIN;
        end
        return s[zupt_pkg::VAL_W-1:0];
    endfunction

    // magnitudes and the saturated, deadbanded debiased sample
    assign diff_mag = diff_reg[zupt_pkg::DIFF_W-1]
        ? zupt_pkg::DIFF_W'(-diff_reg) : zupt_pkg::DIFF_W'(diff_reg);

    always_comb begin
        if (diff_reg[zupt_pkg::DIFF_W-1] != diff_reg[zupt_pkg::ACC_W-1]) begin
            acc_sat = diff_reg[zupt_pkg::DIFF_W-1] ? zupt_pkg::ACC_MIN : zupt_pkg::ACC_MAX;
        end else begin
            acc_sat = diff_reg[zupt_pkg::ACC_W-1:0];
        end
    end

    assign acc_sat_mag = acc_sat[zupt_pkg::ACC_W-1]
        ? zupt_pkg::ACC_W'(-acc_sat) : zupt_pkg::ACC_W'(acc_sat);
    assign acc_db = (acc_sat_mag < {1'b0, cfg.accel_deadband}) ? '0 : acc_sat;

    assign accel_mag = accel_reg[zupt_pkg::ACC_W-1]
        ? zupt_pkg::ACC_W'(-accel_reg) : zupt_pkg::ACC_W'(accel_reg);
    assign vel_mag = vel_reg[zupt_pkg::VAL_W-1]
        ? zupt_pkg::VAL_W'(-vel_reg) : zupt_pkg::VAL_W'(vel_reg);

    assign snap = (mul_rmag < {1'b0, cfg.velocity_snap})
        && (accel_mag < {1'b0, cfg.accel_deadband});

    assign status.clear_item = func_reg;
    assign status.hold       = run_reg >= cfg.hold_count;
    assign status.track      = still_reg
        && (diff_mag < {{(zupt_pkg::DIFF_W-zupt_pkg::BAND_W){1'b0}}, cfg.bias_track_limit});
    assign status.out_free   = !m_valid_reg || m_ready;

    // operand select for the shared multiplier
    always_comb begin
        mul_mag        = {{(zupt_pkg::MAG_W-zupt_pkg::DIFF_W){1'b0}}, diff_mag};
        mul_k          = {{(zupt_pkg::K_W-zupt_pkg::FACT_W){1'b0}}, cfg.bias_weight};
        mul_shift_time = 1'b0;
        mul_neg        = diff_reg[zupt_pkg::DIFF_W-1];
        unique case (cmd.op)
            zupt_pkg::OP_MUL_ACC: begin
                mul_mag        = {{(zupt_pkg::MAG_W-zupt_pkg::ACC_W){1'b0}}, accel_mag};
                mul_k          = dt_reg;
                mul_shift_time = 1'b1;
                mul_neg        = accel_reg[zupt_pkg::ACC_W-1];
            end
            zupt_pkg::OP_MUL_DECAY: begin
                mul_mag = vel_mag;
                mul_k   = {{(zupt_pkg::K_W-zupt_pkg::FACT_W){1'b0}}, cfg.velocity_decay};
                mul_neg = vel_reg[zupt_pkg::VAL_W-1];
            end
            zupt_pkg::OP_MUL_POS: begin
                mul_mag        = vel_mag;
                mul_k          = dt_reg;
                mul_shift_time = 1'b1;
                mul_neg        = vel_reg[zupt_pkg::VAL_W-1];
            end
            default: begin
                // bias operands
            end
        endcase
    end

    zupt_mul u_mul (
        .aclk       (aclk),
        .start      (cmd.mul_start),
        .mag        (mul_mag),
        .k          (mul_k),
        .shift_time (mul_shift_time),
        .neg        (mul_neg),
        .rmag       (mul_rmag),
        .rneg       (mul_rneg)
    );

    always_comb begin
        run_next     = run_reg;
        pos_next     = pos_reg;
        vel_next     = vel_reg;
        bias_next    = bias_reg;
        accel_next   = accel_reg;
        held_next    = held_reg;
        diff_next    = {sample_reg[zupt_pkg::ACC_W-1], sample_reg}
                     - {bias_reg[zupt_pkg::ACC_W-1], bias_reg};
        m_valid_next = m_valid_reg && !m_ready;
        unique case (cmd.op)
            zupt_pkg::OP_STEP: begin
                held_next = 1'b0;
                if (func_reg) begin
                    run_next   = '0;
                    pos_next   = '0;
                    vel_next   = '0;
                    bias_next  = '0;
                    accel_next = '0;
                end else if (still_reg) begin
                    // saturate the stationary run
                    if (run_reg != zupt_pkg::RUN_MAX) begin
                        run_next = run_reg + 1'b1;
                    end
                end else begin
                    run_next = '0;
                end
            end
            zupt_pkg::OP_DECIDE: begin
                if (status.hold) begin
                    held_next  = 1'b1;
                    vel_next   = '0;
                    accel_next = '0;
                end else begin
                    accel_next = acc_db;
                end
            end
            zupt_pkg::OP_ADD_BIAS: begin
                // step stays within the sample-bias gap, so 24 bits suffice
                bias_next = mul_rneg
                    ? bias_reg - $signed(mul_rmag[zupt_pkg::ACC_W-1:0])
                    : bias_reg + $signed(mul_rmag[zupt_pkg::ACC_W-1:0]);
            end
            zupt_pkg::OP_ADD_VEL: begin
                vel_next = sat_addsub(vel_reg, mul_rmag, mul_rneg);
            end
            zupt_pkg::OP_SET_VEL: begin
                if (snap) begin
                    vel_next = '0;
                end else begin
                    vel_next = mul_rneg ? $signed(zupt_pkg::VAL_W'(0) - mul_rmag)
                                        : $signed(mul_rmag);
                end
            end
            zupt_pkg::OP_ADD_POS: begin
                pos_next = sat_addsub(pos_reg, mul_rmag, mul_rneg);
            end
            zupt_pkg::OP_EMIT: begin
                m_valid_next = 1'b1;
            end
            default: begin
                // no state change
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= '0;
            pos_reg     <= '0;
            vel_reg     <= '0;
            bias_reg    <= '0;
            accel_reg   <= '0;
            held_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            run_reg     <= run_next;
            pos_reg     <= pos_next;
            vel_reg     <= vel_next;
            bias_reg    <= bias_next;
            accel_reg   <= accel_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == zupt_pkg::OP_LOAD) begin
            func_reg   <= s_data.func;
            sample_reg <= s_data.accel_sample;
            dt_reg     <= s_data.time_step;
            still_reg  <= s_data.still;
        end
        if (cmd.op == zupt_pkg::OP_STEP) begin
            diff_reg <= diff_next;
        end
        if (cmd.op == zupt_pkg::OP_EMIT) begin
            m_data_reg.position   <= pos_reg;
            m_data_reg.velocity   <= vel_reg;
            m_data_reg.accel_used <= accel_reg;
            m_data_reg.bias_now   <= bias_reg;
            m_data_reg.held       <= held_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ZUPT_ASSERT_NEXT(a_held_no_motion, aclk, aresetn, (cmd.op == zupt_pkg::OP_EMIT) && held_reg, (m_data.velocity == '0) && (m_data.accel_used == '0), "held result carries motion")
    `ZUPT_ASSERT_NEXT(a_run_saturates, aclk, aresetn, (cmd.op == zupt_pkg::OP_STEP) && !func_reg && still_reg && (run_reg == zupt_pkg::RUN_MAX), run_reg == zupt_pkg::RUN_MAX, "stationary run wrapped")
    `ZUPT_ASSERT_IMP(a_term_range, aclk, aresetn, (cmd.op == zupt_pkg::OP_ADD_VEL) || (cmd.op == zupt_pkg::OP_ADD_POS) || (cmd.op == zupt_pkg::OP_SET_VEL), !mul_rmag[zupt_pkg::MAG_W-1], "rounded product out of range")

endmodule

FILE: rtl/core/zupt_axis_dead_reckoning_core.sv
// Top level of the one-axis dead-reckoning core with zero-velocity update.
//
//   port group     dir   handshake           payload
//   s_*            in    s_valid / s_ready   s_data  (zupt_pkg::in_item_t)
//   m_*            out   m_valid / m_ready   m_data  (zupt_pkg::out_item_t)
//   cfg_*          in    cfg_wr_en           cfg_wr_index, cfg_wr_data
//
// One request at a time, paced by the shared multiplier. A moving sample goes
// through step, decide, vel mul/add, decay mul/set, pos mul/add and out; a held
// sample through step, decide, bias mul/add if tracking, out; a clear request step, out.
// The result sits in an output register, so a stalled m_ready only delays the
// next request when its own result is ready to be written.
// aresetn is synchronous and active low; it zeroes the state and loads the
// register defaults. No clearing pass is needed after reset.
module zupt_axis_dead_reckoning_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [zupt_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [zupt_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  zupt_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output zupt_pkg::out_item_t              m_data
);

    zupt_pkg::cfg_t       cfg;
    zupt_pkg::dp_cmd_t    cmd;
    zupt_pkg::dp_status_t status;

    zupt_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    zupt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    zupt_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .cmd     (cmd),
        .status  (status),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
